[rtl/core/ste_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types, widths and codes of the scope edge trigger search block.
// ----------------------------------------------------------------------------
package ste_pkg;

  // Default sizes of the sample ring
  localparam int unsigned DEF_BUF_DEPTH   = 2048;
  localparam int unsigned DEF_SAMPLE_BITS = 12;

  // Fixed field widths
  localparam int unsigned THR_W      = 12;
  localparam int unsigned FB_W       = 10;
  localparam int unsigned OUT_IDX_W  = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_FALLING  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_BACK = 2'd2;

  // Register reset values
  localparam logic [THR_W-1:0] RST_THRESHOLD     = 12'd2048;
  localparam logic             RST_EDGE_FALLING  = 1'b0;
  localparam logic [FB_W-1:0]  RST_FALLBACK_BACK = 10'd64;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QP_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QC_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FALLBACK,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic             edge_falling;
    logic [FB_W-1:0]  fallback_back;
  } cfg_t;

  // Head of the command queue, front to back
  typedef struct packed {
    logic valid;
    op_e  op;
  } q_head_t;

  // Back status, back to front
  typedef struct packed {
    logic pop;
    logic busy;
  } bk_stat_t;

endpackage
`default_nettype wire

[rtl/core/ste_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ste_in_if
// Input channel: one beat carries a command and a converter sample.
// ----------------------------------------------------------------------------
interface ste_in_if
  import ste_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink   (input valid, input cmd, input sample, output ready);
endinterface
`default_nettype wire

[rtl/core/ste_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ste_out_if
// Result channel: one beat carries a trigger index and the found flag.
// ----------------------------------------------------------------------------
interface ste_out_if
  import ste_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] trigger_index;
  logic                 found;

  modport source (output valid, output trigger_index, output found, input ready);
  modport sink   (input valid, input trigger_index, input found, output ready);
endinterface
`default_nettype wire

[rtl/core/ste_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ste_front
// Accepts input beats, decodes the command and queues them for the back.
// ----------------------------------------------------------------------------
module ste_front
  import ste_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  ste_in_if.sink                      in_ch,
  input  wire bk_stat_t               stat_i,
  output      q_head_t                head_o,
  output      logic [SAMPLE_BITS-1:0] head_sample_o
);

  op_e                    op_q [QUEUE_DEPTH];
  logic [SAMPLE_BITS-1:0] smp_q [QUEUE_DEPTH];
  logic [QP_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [QP_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0]        cnt_q, cnt_d;
  logic                   push;
  logic                   pop;
  op_e                    op_dec;

  // Decode the command of the incoming beat
  assign op_dec = (in_ch.cmd == 1'b1) ? OP_SEARCH : OP_WRITE;

  assign in_ch.ready = (cnt_q != QC_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid & in_ch.ready;
  assign pop         = stat_i.pop & (cnt_q != '0);

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the beat in the queue slot
  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]  <= op_dec;
      smp_q[wr_ptr_q] <= in_ch.sample;
    end
  end

  assign head_o.valid  = (cnt_q != '0);
  assign head_o.op     = op_q[rd_ptr_q];
  assign head_sample_o = smp_q[rd_ptr_q];

endmodule
`default_nettype wire

[rtl/core/ste_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ste_back
// Holds the sample ring, writes samples and walks the ring backward for
// the latest threshold crossing, then presents the result beat.
// ----------------------------------------------------------------------------
module ste_back
  import ste_pkg::*;
#(
  parameter int unsigned BUF_DEPTH   = DEF_BUF_DEPTH,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire q_head_t                head_i,
  input  wire logic [SAMPLE_BITS-1:0] head_sample_i,
  output      bk_stat_t               stat_o,
  ste_out_if.source                   out_ch
);

  localparam int unsigned IDX_W = $clog2(BUF_DEPTH);
  localparam int unsigned HALF  = BUF_DEPTH / 2;
  localparam int unsigned CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int unsigned FBX_W = ((IDX_W > FB_W) ? IDX_W : FB_W) + 1;
  localparam int unsigned XW    = IDX_W + OUT_IDX_W;

  // Sample ring
  logic [SAMPLE_BITS-1:0] ring_q [BUF_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic [IDX_W-1:0]       rd_addr;
  logic                   mem_we;

  back_state_e            state_q, state_d;
  logic [IDX_W-1:0]       wp_q, wp_d;
  logic [IDX_W-1:0]       newest_q, newest_d;
  logic [IDX_W-1:0]       cur_q, cur_d;
  logic [IDX_W-1:0]       lag_q, lag_d;
  logic [IDX_W-1:0]       cnt_q, cnt_d;
  logic                   first_q, first_d;
  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [FBX_W-1:0]       fb_q, fb_d;
  logic [IDX_W-1:0]       res_idx_q, res_idx_d;
  logic                   res_found_q, res_found_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_IDX_W-1:0]   out_idx_q, out_idx_d;
  logic                   out_found_q, out_found_d;

  logic [CMP_W-1:0]       a_x, b_x, thr_x;
  logic                   hit;
  logic [FBX_W-1:0]       newest_x, fb_diff;
  logic [XW-1:0]          res_ext;
  logic                   slot_free;

  // Compare the pair (ring[i], ring[i+1]) against the threshold
  assign a_x   = CMP_W'(rd_data_q);
  assign b_x   = CMP_W'(prev_q);
  assign thr_x = CMP_W'(cfg_i.threshold);
  assign hit   = cfg_i.edge_falling ? ((a_x >= thr_x) && (b_x < thr_x))
                                    : ((a_x <= thr_x) && (b_x > thr_x));

  // Newest minus fallback distance, wrapped to the ring
  assign newest_x = FBX_W'(newest_q);
  assign fb_diff  = (newest_x >= fb_q) ? (newest_x - fb_q)
                                       : (newest_x + FBX_W'(BUF_DEPTH) - fb_q);

  assign slot_free = !out_valid_q || out_ch.ready;
  assign res_ext   = XW'(res_idx_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    newest_d    = newest_q;
    cur_d       = cur_q;
    lag_d       = lag_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    prev_d      = prev_q;
    fb_d        = fb_q;
    res_idx_d   = res_idx_q;
    res_found_d = res_found_q;
    rd_addr     = cur_q;
    mem_we      = 1'b0;
    stat_o.pop  = 1'b0;
    stat_o.busy = (state_q != ST_IDLE);
    out_valid_d = out_ch.ready ? 1'b0 : out_valid_q;
    out_idx_d   = out_idx_q;
    out_found_d = out_found_q;

    case (state_q)
      ST_IDLE: begin
        rd_addr = wp_q;
        if (head_i.valid) begin
          stat_o.pop = 1'b1;
          if (head_i.op == OP_WRITE) begin
            mem_we   = 1'b1;
            newest_d = wp_q;
            wp_d     = (wp_q == IDX_W'(BUF_DEPTH - 1)) ? '0 : wp_q + 1'b1;
          end else begin
            // Read the oldest slot first as partner of the newest
            first_d = 1'b1;
            cur_d   = newest_q;
            cnt_d   = '0;
            fb_d    = FBX_W'(cfg_i.fallback_back);
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_addr = cur_q;
        lag_d   = cur_q;
        cur_d   = (cur_q == '0) ? IDX_W'(BUF_DEPTH - 1) : cur_q - 1'b1;
        if (first_q) begin
          prev_d  = rd_data_q;
          first_d = 1'b0;
        end else if (hit) begin
          res_idx_d   = lag_q;
          res_found_d = 1'b1;
          state_d     = ST_EMIT;
        end else begin
          prev_d = rd_data_q;
          cnt_d  = cnt_q + 1'b1;
          if (cnt_q == IDX_W'(HALF - 1)) begin
            state_d = ST_FALLBACK;
          end
        end
      end
      ST_FALLBACK: begin
        // Reduce the fallback distance below the ring depth
        if (fb_q >= FBX_W'(BUF_DEPTH)) begin
          fb_d = fb_q - FBX_W'(BUF_DEPTH);
        end else begin
          res_idx_d   = fb_diff[IDX_W-1:0];
          res_found_d = 1'b0;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = res_ext[OUT_IDX_W-1:0];
          out_found_d = res_found_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      newest_q    <= IDX_W'(BUF_DEPTH - 1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      newest_q    <= newest_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    lag_q       <= lag_d;
    cnt_q       <= cnt_d;
    first_q     <= first_d;
    prev_q      <= prev_d;
    fb_q        <= fb_d;
    res_idx_q   <= res_idx_d;
    res_found_q <= res_found_d;
    out_idx_q   <= out_idx_d;
    out_found_q <= out_found_d;
  end

  // Ring memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[wp_q] <= head_sample_i;
    end
    rd_data_q <= ring_q[rd_addr];
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.trigger_index = out_idx_q;
  assign out_ch.found         = out_found_q;

endmodule
`default_nettype wire

[rtl/core/scope_edge_trigger_search.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scope_edge_trigger_search
// Edge trigger finder over a ring of converter samples.
// ----------------------------------------------------------------------------
// A sample beat (cmd 0) is stored at the write pointer in the back end and
// gives no result. A search beat (cmd 1) walks the ring backward from the
// newest sample over BUF_DEPTH/2 pairs and returns the latest crossing of
// the threshold in the configured direction, or newest minus fallback_back
// with found cleared. The single read port of the ring gives one sample a
// cycle. A four-entry command queue takes beats while a search runs, and
// the result register lets the next beats go on while a result waits. The
// user must see that configuration is written only while the block is
// idle; the block itself does not enforce this. Ring entries are not
// cleared at reset; a search must not reach slots never written.
// ----------------------------------------------------------------------------
module scope_edge_trigger_search
  import ste_pkg::*;
#(
  parameter int unsigned BUF_DEPTH   = DEF_BUF_DEPTH,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ste_in_if.sink                     in_ch,
  ste_out_if.source                  out_ch,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t                   cfg_q, cfg_d;
  q_head_t                head;
  logic [SAMPLE_BITS-1:0] head_sample;
  bk_stat_t               stat;

  // Register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD:     cfg_d.threshold     = cfg_data_i[THR_W-1:0];
        CFG_EDGE_FALLING:  cfg_d.edge_falling  = cfg_data_i[0];
        CFG_FALLBACK_BACK: cfg_d.fallback_back = cfg_data_i[FB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold     <= RST_THRESHOLD;
      cfg_q.edge_falling  <= RST_EDGE_FALLING;
      cfg_q.fallback_back <= RST_FALLBACK_BACK;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ste_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .stat_i        (stat),
    .head_o        (head),
    .head_sample_o (head_sample)
  );

  ste_back #(
    .BUF_DEPTH   (BUF_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (head),
    .head_sample_i (head_sample),
    .stat_o        (stat),
    .out_ch        (out_ch)
  );

  // The back only takes a beat from a non-empty queue
  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pop |-> head.valid)
    else $error("queue popped while empty");

  // No beat is taken while a search is under way
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> !stat.pop)
    else $error("queue popped during a search");

  // A write to an unknown register leaves the registers alone
  a_cfg_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i != CFG_THRESHOLD) && (cfg_idx_i != CFG_EDGE_FALLING)
     && (cfg_idx_i != CFG_FALLBACK_BACK)) |=> $stable(cfg_q))
    else $error("unknown register index changed the configuration");

endmodule
`default_nettype wire
